FILE: rtl/core/debounced_pulse_counter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debounced pulse counter
// Clocked checks with an active-low reset that disables them.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_PULSE_COUNTER_TOP_MACROS_SVH
`define DEBOUNCED_PULSE_COUNTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared widths, register codes and the configuration type.
// ----------------------------------------------------------------------------
package dpc_pkg;

  // Payload widths
  localparam int CHAN_W     = 3;
  localparam int TS_W       = 48;
  localparam int TOTAL_W    = 32;
  localparam int MIN_W      = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  // 150 ms at 50 kHz timer ticks
  localparam int unsigned MIN_TICKS_DEFAULT = 150000 * 50 / 1000;
  localparam logic [MIN_W-1:0] MIN_TICKS_RST = MIN_W'(MIN_TICKS_DEFAULT);
  localparam logic ACTIVE_LEVEL_RST = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE_TICKS = 8'd0,
    CFG_ACTIVE_LEVEL    = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [MIN_W-1:0] min_pulse_ticks;
    logic             active_level;
  } cfg_t;

endpackage

FILE: rtl/core/dpc_intf.sv
// ----------------------------------------------------------------------------
// dpc_intf
// Valid/ready channels: pin events, count results and register writes.
// ----------------------------------------------------------------------------
interface dpc_event_if;
  import dpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic              pin_level;
  logic [TS_W-1:0]   timestamp;

  modport source (output valid, channel, pin_level, timestamp, input ready);
  modport sink   (input valid, channel, pin_level, timestamp, output ready);
endinterface

interface dpc_result_if;
  import dpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  channel_out;
  logic [TOTAL_W-1:0] pulse_total;
  logic               counted;

  modport source (output valid, channel_out, pulse_total, counted, input ready);
  modport sink   (input valid, channel_out, pulse_total, counted, output ready);
endinterface

interface dpc_cfg_if;
  import dpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dpc_cfg_regs
// Configuration registers: minimum pulse width and active pin level.
// ----------------------------------------------------------------------------
module dpc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpc_cfg_if.sink       cfg_i,
  output dpc_pkg::cfg_t cfg_o
);
  import dpc_pkg::*;

  cfg_t cfg_q;

  // Accept every write request at once
  assign cfg_i.ready = 1'b1;

  // Update the addressed register, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse_ticks <= MIN_TICKS_RST;
      cfg_q.active_level    <= ACTIVE_LEVEL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MIN_PULSE_TICKS: cfg_q.min_pulse_ticks <= cfg_i.data[MIN_W-1:0];
        CFG_ACTIVE_LEVEL:    cfg_q.active_level    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/dpc_state_mem.sv
// ----------------------------------------------------------------------------
// dpc_state_mem
// Per-channel state memory with registered read, entry valid bits and
// forwarding of the write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module dpc_state_mem #(
  parameter int NUM_CHANNELS = 8,
  parameter int TIME_BITS    = 48,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [IDX_W-1:0]            rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [TIME_BITS-1:0]        wr_start_i,
  input  logic                        wr_pending_i,
  input  logic [dpc_pkg::TOTAL_W-1:0] wr_count_i,
  output logic [TIME_BITS-1:0]        rd_start_o,
  output logic                        rd_pending_o,
  output logic [dpc_pkg::TOTAL_W-1:0] rd_count_o
);
  import dpc_pkg::*;

  localparam int ENTRY_W = TIME_BITS + 1 + TOTAL_W;

  logic [ENTRY_W-1:0] mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid_q;

  logic [ENTRY_W-1:0] wr_word;
  logic [ENTRY_W-1:0] rd_word_q;
  logic               rd_valid_q;
  logic               fwd_hit_q;
  logic [ENTRY_W-1:0] fwd_word_q;
  logic [ENTRY_W-1:0] rd_word;

  assign wr_word = {wr_start_i, wr_pending_i, wr_count_i};

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word;
    end
  end

  // Mark entries as written; an unwritten entry reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Read port and capture of a write to the same entry on this edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word_q  <= mem[rd_addr_i];
      fwd_word_q <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= valid_q[rd_addr_i];
      fwd_hit_q  <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  // Select forwarded, stored or reset value
  always_comb begin
    if (fwd_hit_q) begin
      rd_word = fwd_word_q;
    end else if (rd_valid_q) begin
      rd_word = rd_word_q;
    end else begin
      rd_word = '0;
    end
  end

  assign {rd_start_o, rd_pending_o, rd_count_o} = rd_word;

endmodule

FILE: rtl/core/dpc_update.sv
// ----------------------------------------------------------------------------
// dpc_update
// Per-event state update: start a pulse, or close it and qualify its width.
// ----------------------------------------------------------------------------
module dpc_update #(
  parameter int TIME_BITS = 48
) (
  input  dpc_pkg::cfg_t               cfg_i,
  input  logic                        in_range_i,
  input  logic                        pin_level_i,
  input  logic [dpc_pkg::TS_W-1:0]    timestamp_i,
  input  logic [TIME_BITS-1:0]        cur_start_i,
  input  logic                        cur_pending_i,
  input  logic [dpc_pkg::TOTAL_W-1:0] cur_count_i,
  output logic [TIME_BITS-1:0]        nxt_start_o,
  output logic                        nxt_pending_o,
  output logic [dpc_pkg::TOTAL_W-1:0] nxt_count_o,
  output logic                        we_o,
  output logic                        counted_o,
  output logic [dpc_pkg::TOTAL_W-1:0] total_o
);
  import dpc_pkg::*;

  logic [63:0]          ts_ext;
  logic [63:0]          min_ext;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] min_ticks;
  logic [TIME_BITS-1:0] elapsed;
  logic                 wide_enough;

  // Bring time values to the timer width, wrapping modulo its range
  assign ts_ext      = 64'(timestamp_i);
  assign min_ext     = 64'(cfg_i.min_pulse_ticks);
  assign now         = ts_ext[TIME_BITS-1:0];
  assign min_ticks   = min_ext[TIME_BITS-1:0];
  assign elapsed     = now - cur_start_i;
  assign wide_enough = (elapsed >= min_ticks);

  // Decide the new entry
  always_comb begin
    nxt_start_o   = cur_start_i;
    nxt_pending_o = cur_pending_i;
    nxt_count_o   = cur_count_i;
    we_o          = 1'b0;
    counted_o     = 1'b0;
    if (in_range_i) begin
      if (pin_level_i == cfg_i.active_level) begin
        nxt_start_o   = now;
        nxt_pending_o = 1'b1;
        we_o          = 1'b1;
      end else if (cur_pending_i) begin
        nxt_pending_o = 1'b0;
        we_o          = 1'b1;
        if (wide_enough) begin
          nxt_count_o = cur_count_i + TOTAL_W'(1);
          counted_o   = 1'b1;
        end
      end
    end
  end

  // Report zero for channels the block does not have
  assign total_o = in_range_i ? nxt_count_o : '0;

endmodule

FILE: rtl/core/debounced_pulse_counter_top.sv
// ----------------------------------------------------------------------------
// debounced_pulse_counter_top
// Multi-channel pulse counter with a minimum-width filter.
// ----------------------------------------------------------------------------
//  port   | dir | requests carried
//  -------+-----+---------------------------------------------------
//  evt_i  | in  | pin event: channel, pin_level, timestamp
//  res_o  | out | result: channel_out, pulse_total, counted
//  cfg_i  | in  | register write: index, data (always ready)
//
//  Throughput is one event per cycle while results are taken; from accept,
//  an event passes the registered state memory read and the result register.
//  A write-back to the channel read on the same edge is forwarded.
//  Reset clears all channel state at once through per-entry valid bits.
//  A stalled result holds the update stage and, once that is full, the input.
// ----------------------------------------------------------------------------
`include "debounced_pulse_counter_top_macros.svh"

module debounced_pulse_counter_top #(
  parameter int NUM_CHANNELS = 8,
  parameter int TIME_BITS    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpc_event_if.sink   evt_i,
  dpc_result_if.source res_o,
  dpc_cfg_if.sink     cfg_i
);
  import dpc_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [7:0] NUM_CH_L = 8'(NUM_CHANNELS);

  cfg_t cfg;

  // Handshake control
  logic in_ready;
  logic accept;
  logic out_free;
  logic s1_adv;

  // Input side decode
  logic [7:0]       evt_ch_ext;
  logic             evt_in_range;
  logic [IDX_W-1:0] evt_addr;

  // Update stage
  logic              s1_valid_q;
  logic [CHAN_W-1:0] s1_ch_q;
  logic              s1_level_q;
  logic [TS_W-1:0]   s1_ts_q;
  logic              s1_in_range_q;
  logic [7:0]        s1_ch_ext;
  logic [IDX_W-1:0]  s1_addr;

  // State read and write-back
  logic [TIME_BITS-1:0] cur_start;
  logic                 cur_pending;
  logic [TOTAL_W-1:0]   cur_count;
  logic [TIME_BITS-1:0] nxt_start;
  logic                 nxt_pending;
  logic [TOTAL_W-1:0]   nxt_count;
  logic                 upd_we;
  logic                 upd_counted;
  logic [TOTAL_W-1:0]   upd_total;

  // Output register
  logic               res_valid_q;
  logic [CHAN_W-1:0]  res_ch_q;
  logic [TOTAL_W-1:0] res_total_q;
  logic               res_counted_q;
  logic [7:0]         res_ch_ext;
  logic               res_in_range;

  dpc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Advance the pipeline whenever the output slot frees up
  assign out_free    = !res_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_ready    = !s1_valid_q || out_free;
  assign accept      = evt_i.valid && in_ready;
  assign evt_i.ready = in_ready;

  assign evt_ch_ext   = 8'(evt_i.channel);
  assign evt_in_range = (evt_ch_ext < NUM_CH_L);
  assign evt_addr     = evt_ch_ext[IDX_W-1:0];
  assign s1_ch_ext    = 8'(s1_ch_q);
  assign s1_addr      = s1_ch_ext[IDX_W-1:0];

  dpc_state_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIME_BITS    (TIME_BITS),
    .IDX_W        (IDX_W)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept && evt_in_range),
    .rd_addr_i    (evt_addr),
    .wr_en_i      (s1_adv && upd_we),
    .wr_addr_i    (s1_addr),
    .wr_start_i   (nxt_start),
    .wr_pending_i (nxt_pending),
    .wr_count_i   (nxt_count),
    .rd_start_o   (cur_start),
    .rd_pending_o (cur_pending),
    .rd_count_o   (cur_count)
  );

  dpc_update #(
    .TIME_BITS (TIME_BITS)
  ) u_upd (
    .cfg_i         (cfg),
    .in_range_i    (s1_in_range_q),
    .pin_level_i   (s1_level_q),
    .timestamp_i   (s1_ts_q),
    .cur_start_i   (cur_start),
    .cur_pending_i (cur_pending),
    .cur_count_i   (cur_count),
    .nxt_start_o   (nxt_start),
    .nxt_pending_o (nxt_pending),
    .nxt_count_o   (nxt_count),
    .we_o          (upd_we),
    .counted_o     (upd_counted),
    .total_o       (upd_total)
  );

  // Hold the event in the update stage while its state is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q       <= evt_i.channel;
      s1_level_q    <= evt_i.pin_level;
      s1_ts_q       <= evt_i.timestamp;
      s1_in_range_q <= evt_in_range;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_ch_q      <= s1_ch_q;
      res_total_q   <= upd_total;
      res_counted_q <= upd_counted;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.channel_out = res_ch_q;
  assign res_o.pulse_total = res_total_q;
  assign res_o.counted     = res_counted_q;

  assign res_ch_ext   = 8'(res_ch_q);
  assign res_in_range = (res_ch_ext < NUM_CH_L);

  `DPC_ASSERT_NEXT(a_adv_loads_result, clk_i, rst_ni, s1_adv, res_valid_q,
                   "update stage advanced without loading a result")
  `DPC_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, !in_ready,
                  s1_valid_q && res_valid_q && !res_o.ready,
                  "input stalled while the pipeline had room")
  `DPC_ASSERT_NOW(a_absent_channel_zero, clk_i, rst_ni, res_valid_q && !res_in_range,
                  (res_total_q == '0) && !res_counted_q,
                  "absent channel reported a nonzero count")

endmodule
